[rtl/core/assert_macros.svh]
// Assertion macros used by the sequencer RTL.
// Checks compile only in simulation; synthesis sees empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property checked on every clock edge outside reset.
`define SPS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked on every clock edge, reset included.
`define SPS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define SPS_ASSERT(lbl, clk, rst_n, prop, msg)
`define SPS_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

[rtl/core/sps_pkg.sv]
`default_nettype none

package sps_pkg;

    // Phase table geometry
    localparam int PHASE_COUNT     = 8;
    localparam int PHASE_IDX_BITS  = $clog2(PHASE_COUNT);
    localparam int FWD_COUNT       = 5;
    localparam int ANGLE_BITS_DFLT = 16;
    localparam int TOL_BITS        = 12;
    localparam int GAIN_BITS       = 6;
    localparam int CFG_IDX_BITS    = 3;

    // Target slots: forward leg, then backward leg
    localparam int PH_FWD_MIN      = 0;
    localparam int PH_FWD_MIN_HALF = 1;
    localparam int PH_FWD_ZERO     = 2;
    localparam int PH_FWD_MAX_HALF = 3;
    localparam int PH_FWD_MAX      = 4;
    localparam int PH_BWD_MAX_HALF = 5;
    localparam int PH_BWD_ZERO     = 6;
    localparam int PH_BWD_MIN_HALF = 7;

    // Configuration register map
    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_HIT_TOLERANCE = 3'd0,
        CFG_LEAD_GAIN     = 3'd1,
        CFG_HIP_UPPER     = 3'd2,
        CFG_HIP_LOWER     = 3'd3,
        CFG_KNEE_UPPER    = 3'd4,
        CFG_KNEE_LOWER    = 3'd5
    } t_cfg_reg;

    // Reset values, Q13 radians
    localparam logic [TOL_BITS-1:0]  HIT_TOL_RST    = 12'd246;
    localparam logic [GAIN_BITS-1:0] LEAD_GAIN_RST  = 6'd15;
    localparam int                   HIP_UPPER_RST  = 3932;
    localparam int                   HIP_LOWER_RST  = -12534;
    localparam int                   KNEE_UPPER_RST = 17203;
    localparam int                   KNEE_LOWER_RST = -737;
    localparam int                   SWING_MAX_RST  = 3604;
    localparam int                   SWING_MIN_RST  = -2785;

    // Fixed pose table per phase
    localparam logic signed [31:0] LEG_ROM [PHASE_COUNT] = '{
        32'sd16335, -32'sd819, -32'sd819, -32'sd472,
        32'sd8585, 32'sd14729, 32'sd15581, 32'sd15581
    };
    localparam logic signed [31:0] BODY_ROM [PHASE_COUNT] = '{
        -32'sd8282, -32'sd4088, -32'sd4047, -32'sd5259,
        -32'sd8167, -32'sd9994, -32'sd9069, -32'sd9249
    };

    // Match result handed from the comparator bank to the top level
    typedef struct packed {
        logic                      hit;
        logic [PHASE_IDX_BITS-1:0] index;
    } t_match;

    // When limits cross: hi if a > hi, else lo (upper tested first)
    function automatic logic signed [31:0] clamp_hi_lo(
        input logic signed [31:0] a,
        input logic signed [31:0] hi,
        input logic signed [31:0] lo
    );
        logic signed [31:0] res;
        res = a;
        if (a > hi) begin
            res = hi;
        end else if (a < lo) begin
            res = lo;
        end
        return res;
    endfunction

endpackage

`default_nettype wire

[rtl/core/sps_phase_match.sv]
`default_nettype none

// Window comparator bank over the phase targets, last hit wins.
module sps_phase_match #(
    parameter int ANGLE_BITS = sps_pkg::ANGLE_BITS_DFLT
) (
    input  wire logic signed [ANGLE_BITS-1:0]          i_pitch,
    input  wire logic signed [ANGLE_BITS+7:0]          i_lead,
    input  wire logic signed [ANGLE_BITS-1:0]          i_swing_min,
    input  wire logic signed [ANGLE_BITS-1:0]          i_swing_max,
    input  wire logic                                  i_forward,
    input  wire logic        [sps_pkg::TOL_BITS-1:0]   i_tol,
    output sps_pkg::t_match                            o_match
);

    localparam int DW = ANGLE_BITS + 9;

    logic signed [ANGLE_BITS-1:0] w_min_half;
    logic signed [ANGLE_BITS-1:0] w_max_half;
    logic signed [ANGLE_BITS-1:0] w_target [sps_pkg::PHASE_COUNT];
    logic        [sps_pkg::PHASE_COUNT-1:0] w_win;

    // Halving rounds toward minus infinity
    assign w_min_half = i_swing_min >>> 1;
    assign w_max_half = i_swing_max >>> 1;

    always_comb begin
        w_target[sps_pkg::PH_FWD_MIN]      = i_swing_min;
        w_target[sps_pkg::PH_FWD_MIN_HALF] = w_min_half;
        w_target[sps_pkg::PH_FWD_ZERO]     = '0;
        w_target[sps_pkg::PH_FWD_MAX_HALF] = w_max_half;
        w_target[sps_pkg::PH_FWD_MAX]      = i_swing_max;
        w_target[sps_pkg::PH_BWD_MAX_HALF] = w_max_half;
        w_target[sps_pkg::PH_BWD_ZERO]     = '0;
        w_target[sps_pkg::PH_BWD_MIN_HALF] = w_min_half;
    end

    // One strict window test per target: -tol < pitch - (target - lead) < tol
    always_comb begin
        logic signed [DW-1:0] v_diff;
        logic signed [DW-1:0] v_tol;
        logic                 v_en;
        v_tol = $signed(DW'(i_tol));
        for (int i = 0; i < sps_pkg::PHASE_COUNT; i++) begin
            v_en     = i_forward ? (i < sps_pkg::FWD_COUNT) : (i >= sps_pkg::FWD_COUNT);
            v_diff   = DW'(i_pitch) - DW'(w_target[i]) + DW'(i_lead);
            w_win[i] = v_en && (v_diff < v_tol) && (v_diff > -v_tol);
        end
    end

    // Highest matching index is taken
    always_comb begin
        o_match.hit   = |w_win;
        o_match.index = '0;
        for (int i = 0; i < sps_pkg::PHASE_COUNT; i++) begin
            if (w_win[i]) begin
                o_match.index = sps_pkg::PHASE_IDX_BITS'(i);
            end
        end
    end

endmodule

`default_nettype wire

[rtl/core/swing_phase_setpoint_sequencer.sv]
`default_nettype none

// Swing phase setpoint sequencer.
// Input channel (i_in_valid / o_in_ready) carries one sample per transfer: seat pitch
// and angular rate. Output channel (o_out_valid / i_out_ready) returns one result per
// sample: hit flag, phase index, direction and the latched leg/body setpoints.
// Configuration channel (i_cfg_valid / o_cfg_ready, always ready) writes one register
// per transfer; indices beyond the map are dropped. Write only while the block is idle.
// An accepted sample is registered in the input stage, then in the output stage.
// Throughput: one sample per cycle while the receiver takes results. The input stage
// computes direction, swing extremes and the velocity lead (one small multiply); the
// output stage runs the eight window comparators, the pose table lookup and the clamp.
// When the receiver stalls, the result is held and the input register fills; o_in_ready
// drops once both stages hold data, and returns the cycle the output is taken.
// Reset (synchronous, active low) empties both stages, restores the register defaults,
// sets direction forward, previous pitch zero, default swing extremes and zeroed
// setpoints. No clearing pass is needed.
module swing_phase_setpoint_sequencer #(
    parameter int ANGLE_BITS = sps_pkg::ANGLE_BITS_DFLT
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    // sample channel
    input  wire logic                                   i_in_valid,
    output      logic                                   o_in_ready,
    input  wire logic signed [ANGLE_BITS-1:0]           i_swing_pitch,
    input  wire logic signed [ANGLE_BITS-1:0]           i_swing_rate,
    // result channel
    output      logic                                   o_out_valid,
    input  wire logic                                   i_out_ready,
    output      logic                                   o_hit,
    output      logic [sps_pkg::PHASE_IDX_BITS-1:0]     o_phase_index,
    output      logic                                   o_forward,
    output      logic signed [ANGLE_BITS-1:0]           o_leg_setpoint,
    output      logic signed [ANGLE_BITS-1:0]           o_body_setpoint,
    // configuration channel
    input  wire logic                                   i_cfg_valid,
    output      logic                                   o_cfg_ready,
    input  wire logic [sps_pkg::CFG_IDX_BITS-1:0]       i_cfg_index,
    input  wire logic [ANGLE_BITS-1:0]                  i_cfg_data
);

`include "assert_macros.svh"

    localparam int LW = ANGLE_BITS + 8;

    // configuration registers
    logic        [sps_pkg::TOL_BITS-1:0]  r_hit_tol;
    logic        [sps_pkg::GAIN_BITS-1:0] r_lead_gain;
    logic signed [ANGLE_BITS-1:0]         r_hip_upper;
    logic signed [ANGLE_BITS-1:0]         r_hip_lower;
    logic signed [ANGLE_BITS-1:0]         r_knee_upper;
    logic signed [ANGLE_BITS-1:0]         r_knee_lower;

    // swing tracking state, follows the most recently accepted sample
    logic                                 r_dir;
    logic signed [ANGLE_BITS-1:0]         r_prev_pitch;
    logic signed [ANGLE_BITS-1:0]         r_swing_max;
    logic signed [ANGLE_BITS-1:0]         r_swing_min;

    // input stage
    logic                                 r_in_valid;
    logic signed [ANGLE_BITS-1:0]         r_pitch;
    logic signed [LW-1:0]                 r_lead;
    logic                                 r_fwd;

    // output stage
    logic                                 r_out_valid;
    logic                                 r_hit;
    logic [sps_pkg::PHASE_IDX_BITS-1:0]   r_phase_index;
    logic                                 r_out_fwd;
    logic signed [ANGLE_BITS-1:0]         r_leg;
    logic signed [ANGLE_BITS-1:0]         r_body;

    logic                                 w_in_xfer;
    logic                                 w_out_take;
    logic                                 w_in_adv;
    logic                                 n_fwd;
    logic signed [ANGLE_BITS-1:0]         n_swing_max;
    logic signed [ANGLE_BITS-1:0]         n_swing_min;
    logic signed [ANGLE_BITS:0]           n_vel;
    logic signed [LW-1:0]                 n_lead;
    logic signed [31:0]                   n_leg;
    logic signed [31:0]                   n_body;
    sps_pkg::t_match                      w_match;

    // handshake: output register frees the input stage, input stage frees the port
    assign w_out_take  = !r_out_valid || i_out_ready;
    assign w_in_adv    = r_in_valid && w_out_take;
    assign o_in_ready  = !r_in_valid || w_out_take;
    assign w_in_xfer   = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit_tol    <= sps_pkg::HIT_TOL_RST;
            r_lead_gain  <= sps_pkg::LEAD_GAIN_RST;
            r_hip_upper  <= ANGLE_BITS'(sps_pkg::HIP_UPPER_RST);
            r_hip_lower  <= ANGLE_BITS'(sps_pkg::HIP_LOWER_RST);
            r_knee_upper <= ANGLE_BITS'(sps_pkg::KNEE_UPPER_RST);
            r_knee_lower <= ANGLE_BITS'(sps_pkg::KNEE_LOWER_RST);
        end else if (i_cfg_valid) begin
            case (sps_pkg::t_cfg_reg'(i_cfg_index))
                sps_pkg::CFG_HIT_TOLERANCE: begin
                    r_hit_tol <= i_cfg_data[sps_pkg::TOL_BITS-1:0];
                end
                sps_pkg::CFG_LEAD_GAIN: begin
                    r_lead_gain <= i_cfg_data[sps_pkg::GAIN_BITS-1:0];
                end
                sps_pkg::CFG_HIP_UPPER:  r_hip_upper  <= $signed(i_cfg_data);
                sps_pkg::CFG_HIP_LOWER:  r_hip_lower  <= $signed(i_cfg_data);
                sps_pkg::CFG_KNEE_UPPER: r_knee_upper <= $signed(i_cfg_data);
                sps_pkg::CFG_KNEE_LOWER: r_knee_lower <= $signed(i_cfg_data);
                default: ;
            endcase
        end
    end

    // direction, swing extremes and velocity lead of the incoming sample
    always_comb begin
        n_fwd       = i_swing_rate > 0;
        n_swing_min = (n_fwd && !r_dir) ? i_swing_pitch : r_swing_min;
        n_swing_max = (!n_fwd && r_dir) ? i_swing_pitch : r_swing_max;
        n_vel       = (ANGLE_BITS + 1)'(i_swing_pitch) - (ANGLE_BITS + 1)'(r_prev_pitch);
        n_lead      = LW'(n_vel * $signed({1'b0, r_lead_gain}));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dir        <= 1'b1;
            r_prev_pitch <= '0;
            r_swing_max  <= ANGLE_BITS'(sps_pkg::SWING_MAX_RST);
            r_swing_min  <= ANGLE_BITS'(sps_pkg::SWING_MIN_RST);
            r_in_valid   <= 1'b0;
        end else begin
            if (w_in_xfer) begin
                r_dir        <= n_fwd;
                r_prev_pitch <= i_swing_pitch;
                r_swing_max  <= n_swing_max;
                r_swing_min  <= n_swing_min;
                r_in_valid   <= 1'b1;
            end else if (w_in_adv) begin
                r_in_valid <= 1'b0;
            end
        end
    end

    // input stage payload
    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_pitch <= i_swing_pitch;
            r_lead  <= n_lead;
            r_fwd   <= n_fwd;
        end
    end

    // comparator bank; extremes in the state registers belong to the staged sample
    sps_phase_match #(
        .ANGLE_BITS (ANGLE_BITS)
    ) u_match (
        .i_pitch     (r_pitch),
        .i_lead      (r_lead),
        .i_swing_min (r_swing_min),
        .i_swing_max (r_swing_max),
        .i_forward   (r_fwd),
        .i_tol       (r_hit_tol),
        .o_match     (w_match)
    );

    // pose lookup and clamp
    always_comb begin
        n_leg  = sps_pkg::clamp_hi_lo(sps_pkg::LEG_ROM[w_match.index],
                                      32'(r_knee_upper), 32'(r_knee_lower));
        n_body = sps_pkg::clamp_hi_lo(sps_pkg::BODY_ROM[w_match.index],
                                      32'(r_hip_upper), 32'(r_hip_lower));
    end

    // output register; setpoints double as the latched command
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_leg       <= '0;
            r_body      <= '0;
        end else begin
            if (w_out_take) begin
                r_out_valid <= r_in_valid;
            end
            if (w_in_adv && w_match.hit) begin
                r_leg  <= n_leg[ANGLE_BITS-1:0];
                r_body <= n_body[ANGLE_BITS-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_adv) begin
            r_hit         <= w_match.hit;
            r_phase_index <= w_match.index;
            r_out_fwd     <= r_fwd;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_hit           = r_hit;
    assign o_phase_index   = r_phase_index;
    assign o_forward       = r_out_fwd;
    assign o_leg_setpoint  = r_leg;
    assign o_body_setpoint = r_body;

    // checks
    `SPS_ASSERT(a_nohit_idx_zero, i_clk, i_rst_n, o_out_valid && !o_hit |-> o_phase_index == 0, "phase index set without a hit")
    `SPS_ASSERT(a_fwd_idx, i_clk, i_rst_n, o_out_valid && o_hit && o_forward |-> o_phase_index < sps_pkg::FWD_COUNT, "forward hit on a backward target")
    `SPS_ASSERT(a_bwd_idx, i_clk, i_rst_n, o_out_valid && o_hit && !o_forward |-> o_phase_index >= sps_pkg::FWD_COUNT, "backward hit on a forward target")
    `SPS_ASSERT(a_stall_full, i_clk, i_rst_n, !o_in_ready |-> r_in_valid && r_out_valid && !i_out_ready, "input blocked with room in the pipe")
    `SPS_ASSERT(a_nohit_keep, i_clk, i_rst_n, w_in_adv && !w_match.hit |=> $stable(r_leg) && $stable(r_body), "setpoints moved without a hit")

endmodule

`default_nettype wire

[test/testbench.sv]
`timescale 1ns / 100ps

module testbench;

    localparam int ANGLE_W         = sps_pkg::ANGLE_BITS_DFLT;
    localparam int ITEMS_PER_PHASE = 100;
    localparam int RANDOM_PHASES   = 7;
    localparam int DRAIN_CYCLES    = 4;
    localparam int CYCLE_LIMIT     = 200000;

    // Register indexes past the end of the map; writes there must be dropped
    localparam logic [sps_pkg::CFG_IDX_BITS-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [sps_pkg::CFG_IDX_BITS-1:0] CFG_SPARE_HI = 3'd7;

    // Pose table per phase slot
    localparam int LEG_POSE [sps_pkg::PHASE_COUNT] = '{
        16335, -819, -819, -472, 8585, 14729, 15581, 15581
    };
    localparam int BODY_POSE [sps_pkg::PHASE_COUNT] = '{
        -8282, -4088, -4047, -5259, -8167, -9994, -9069, -9249
    };

    typedef struct {
        logic signed [ANGLE_W-1:0] pitch;
        logic signed [ANGLE_W-1:0] rate;
    } t_swing_sample;

    typedef struct packed {
        logic                                hit;
        logic [sps_pkg::PHASE_IDX_BITS-1:0]  phase;
        logic                                fwd;
        logic signed [ANGLE_W-1:0]           leg;
        logic signed [ANGLE_W-1:0]           body;
    } t_setpoint;

    logic                                i_clk         = 1'b0;
    logic                                i_rst_n       = 1'b0;
    logic                                i_in_valid    = 1'b0;
    logic signed [ANGLE_W-1:0]           i_swing_pitch = '0;
    logic signed [ANGLE_W-1:0]           i_swing_rate  = '0;
    logic                                i_out_ready   = 1'b0;
    logic                                i_cfg_valid   = 1'b0;
    logic [sps_pkg::CFG_IDX_BITS-1:0]    i_cfg_index   = '0;
    logic [ANGLE_W-1:0]                  i_cfg_data    = '0;
    logic                                o_in_ready;
    logic                                o_out_valid;
    logic                                o_hit;
    logic [sps_pkg::PHASE_IDX_BITS-1:0]  o_phase_index;
    logic                                o_forward;
    logic signed [ANGLE_W-1:0]           o_leg_setpoint;
    logic signed [ANGLE_W-1:0]           o_body_setpoint;
    logic                                o_cfg_ready;

    swing_phase_setpoint_sequencer dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_swing_pitch   (i_swing_pitch),
        .i_swing_rate    (i_swing_rate),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_hit           (o_hit),
        .o_phase_index   (o_phase_index),
        .o_forward       (o_forward),
        .o_leg_setpoint  (o_leg_setpoint),
        .o_body_setpoint (o_body_setpoint),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    // Clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Shadow configuration
    logic [sps_pkg::TOL_BITS-1:0]  tol_reg  = sps_pkg::HIT_TOL_RST;
    logic [sps_pkg::GAIN_BITS-1:0] gain_reg = sps_pkg::LEAD_GAIN_RST;
    int hip_hi  = sps_pkg::HIP_UPPER_RST;
    int hip_lo  = sps_pkg::HIP_LOWER_RST;
    int knee_hi = sps_pkg::KNEE_UPPER_RST;
    int knee_lo = sps_pkg::KNEE_LOWER_RST;

    // Shadow sequencer state
    logic dir_fwd    = 1'b1;
    int   last_pitch = 0;
    int   hi_turn    = sps_pkg::SWING_MAX_RST;
    int   lo_turn    = sps_pkg::SWING_MIN_RST;
    int   leg_cmd    = 0;
    int   body_cmd   = 0;

    t_swing_sample sample_q[$];
    t_setpoint     pending_setpoints[$];

    int tx_idle_pct  = 23;
    int rx_idle_pct  = 54;
    int results_seen = 0;
    int hits_seen    = 0;
    int mismatches   = 0;
    int cfg_writes   = 0;
    int unsigned cycle_cnt = 0;

    // Upper limit is tested first; with crossed limits, a > hi gives hi, all else lo
    function automatic int clip(input int a, input int hi, input int lo);
        if (a > hi) begin
            return hi;
        end else if (a < lo) begin
            return lo;
        end
        return a;
    endfunction

    function automatic void apply_cfg(input logic [sps_pkg::CFG_IDX_BITS-1:0] idx,
                                      input logic [ANGLE_W-1:0] data);
        case (idx)
            sps_pkg::CFG_HIT_TOLERANCE: tol_reg  = data[sps_pkg::TOL_BITS-1:0];
            sps_pkg::CFG_LEAD_GAIN:     gain_reg = data[sps_pkg::GAIN_BITS-1:0];
            sps_pkg::CFG_HIP_UPPER:     hip_hi   = int'($signed(data));
            sps_pkg::CFG_HIP_LOWER:     hip_lo   = int'($signed(data));
            sps_pkg::CFG_KNEE_UPPER:    knee_hi  = int'($signed(data));
            sps_pkg::CFG_KNEE_LOWER:    knee_lo  = int'($signed(data));
            default: ;
        endcase
    endfunction

    // One tick of the sequencer: direction, turn points, led targets, window match
    function automatic t_setpoint predict_setpoints(input logic signed [ANGLE_W-1:0] pitch,
                                                    input logic signed [ANGLE_W-1:0] rate);
        logic                                was_fwd;
        logic                                fwd;
        logic                                hit;
        logic [sps_pkg::PHASE_IDX_BITS-1:0]  idx;
        int                                  vel;
        int                                  lead;
        int                                  tol;
        int                                  tgt;
        int                                  targets [sps_pkg::PHASE_COUNT];
        t_setpoint                           res;
        was_fwd    = dir_fwd;
        fwd        = (rate > 0);
        dir_fwd    = fwd;
        vel        = int'(pitch) - last_pitch;
        last_pitch = int'(pitch);
        if (fwd && !was_fwd) begin
            lo_turn = int'(pitch);
        end
        if (!fwd && was_fwd) begin
            hi_turn = int'(pitch);
        end
        lead = vel * int'(gain_reg);
        tol  = int'(tol_reg);
        targets[sps_pkg::PH_FWD_MIN]      = lo_turn;
        targets[sps_pkg::PH_FWD_MIN_HALF] = lo_turn >>> 1;
        targets[sps_pkg::PH_FWD_ZERO]     = 0;
        targets[sps_pkg::PH_FWD_MAX_HALF] = hi_turn >>> 1;
        targets[sps_pkg::PH_FWD_MAX]      = hi_turn;
        targets[sps_pkg::PH_BWD_MAX_HALF] = hi_turn >>> 1;
        targets[sps_pkg::PH_BWD_ZERO]     = 0;
        targets[sps_pkg::PH_BWD_MIN_HALF] = lo_turn >>> 1;
        hit = 1'b0;
        idx = '0;
        // later slots override earlier ones
        for (int i = 0; i < sps_pkg::PHASE_COUNT; i++) begin
            tgt = targets[i] - lead;
            if ((fwd ? (i < sps_pkg::FWD_COUNT) : (i >= sps_pkg::FWD_COUNT)) &&
                    int'(pitch) < tgt + tol && int'(pitch) > tgt - tol) begin
                hit = 1'b1;
                idx = sps_pkg::PHASE_IDX_BITS'(i);
            end
        end
        if (hit) begin
            leg_cmd  = clip(LEG_POSE[idx], knee_hi, knee_lo);
            body_cmd = clip(BODY_POSE[idx], hip_hi, hip_lo);
        end
        res.hit   = hit;
        res.phase = idx;
        res.fwd   = fwd;
        res.leg   = ANGLE_W'(leg_cmd);
        res.body  = ANGLE_W'(body_cmd);
        return res;
    endfunction

    // Sample driver: predicts on each transfer, then offers the next sample
    always @(posedge i_clk) begin
        t_swing_sample nxt;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                pending_setpoints.push_back(predict_setpoints(i_swing_pitch, i_swing_rate));
            end
            if (!i_in_valid || o_in_ready) begin
                if (sample_q.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
                    nxt = sample_q.pop_front();
                    i_in_valid    <= 1'b1;
                    i_swing_pitch <= nxt.pitch;
                    i_swing_rate  <= nxt.rate;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: compare each transfer with the oldest prediction
    always @(posedge i_clk) begin
        t_setpoint got;
        t_setpoint exp_sp;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                got = '{o_hit, o_phase_index, o_forward, o_leg_setpoint, o_body_setpoint};
                results_seen++;
                if (got.hit) begin
                    hits_seen++;
                end
                if (pending_setpoints.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("unexpected result: hit=%0d phase=%0d fwd=%0d leg=%0d body=%0d",
                                 got.hit, got.phase, got.fwd, got.leg, got.body);
                    end
                end else begin
                    exp_sp = pending_setpoints.pop_front();
                    if (got.hit !== exp_sp.hit || got.phase !== exp_sp.phase ||
                            got.fwd !== exp_sp.fwd || got.leg !== exp_sp.leg ||
                            got.body !== exp_sp.body) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("result %0d mismatch:", results_seen);
                            $display("  expected hit=%0d phase=%0d fwd=%0d leg=%0d body=%0d",
                                     exp_sp.hit, exp_sp.phase, exp_sp.fwd,
                                     exp_sp.leg, exp_sp.body);
                            $display("  actual   hit=%0d phase=%0d fwd=%0d leg=%0d body=%0d",
                                     got.hit, got.phase, got.fwd, got.leg, got.body);
                        end
                    end
                end
            end
            i_out_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    task automatic push_sample(input int pitch, input int rate);
        t_swing_sample s;
        s.pitch = ANGLE_W'(pitch);
        s.rate  = ANGLE_W'(rate);
        sample_q.push_back(s);
    endtask

    // Holds valid high across back-to-back writes; cfg_release lowers it
    task automatic cfg_write(input logic [sps_pkg::CFG_IDX_BITS-1:0] idx, input int data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= ANGLE_W'(data);
        do @(posedge i_clk); while (!o_cfg_ready);
        apply_cfg(idx, ANGLE_W'(data));
        cfg_writes++;
    endtask

    task automatic cfg_release();
        i_cfg_valid <= 1'b0;
    endtask

    // Checked mid-cycle, when the driver's updates have all settled
    task automatic wait_drained();
        do @(negedge i_clk);
        while (sample_q.size() != 0 || i_in_valid || pending_setpoints.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic int pick_step();
        return ($urandom_range(99) < 85) ? int'($urandom_range(1, 40))
                                         : int'($urandom_range(41, 600));
    endfunction

    function automatic int pick_reach();
        return ($urandom_range(99) < 90) ? int'($urandom_range(300, 6000))
                                         : int'($urandom_range(6001, 32767));
    endfunction

    // Limits: half the time a plausible window, else full range, crossed or raw bits
    task automatic write_limits(input logic [sps_pkg::CFG_IDX_BITS-1:0] up_idx,
                                input logic [sps_pkg::CFG_IDX_BITS-1:0] lo_idx);
        int up_v;
        int lo_v;
        case ($urandom_range(5))
            0: begin
                up_v = 32767;
                lo_v = -32768;
            end
            1: begin
                up_v = -int'($urandom_range(0, 12000));
                lo_v = up_v + int'($urandom_range(1, 12000));
            end
            2: begin
                up_v = int'($urandom_range(0, 65535));
                lo_v = int'($urandom_range(0, 65535));
            end
            default: begin
                up_v = int'($urandom_range(0, 20000));
                lo_v = -int'($urandom_range(0, 20000));
            end
        endcase
        cfg_write(up_idx, up_v);
        cfg_write(lo_idx, lo_v);
    endtask

    task automatic random_config();
        int tol_v;
        int gain_v;
        case ($urandom_range(9))
            0:       tol_v = 0;
            1:       tol_v = 4095;
            2:       tol_v = int'($urandom_range(0, 65535));
            default: tol_v = int'($urandom_range(1, 400));
        endcase
        case ($urandom_range(7))
            0:       gain_v = 0;
            1:       gain_v = 63;
            2:       gain_v = int'($urandom_range(0, 65535));
            default: gain_v = int'($urandom_range(0, 20));
        endcase
        cfg_write(sps_pkg::CFG_HIT_TOLERANCE, tol_v);
        cfg_write(sps_pkg::CFG_LEAD_GAIN, gain_v);
        write_limits(sps_pkg::CFG_HIP_UPPER, sps_pkg::CFG_HIP_LOWER);
        write_limits(sps_pkg::CFG_KNEE_UPPER, sps_pkg::CFG_KNEE_LOWER);
        cfg_release();
    endtask

    // Stimulus
    initial begin
        int  sw_pos;
        int  sw_hi;
        int  sw_lo;
        int  sw_step;
        bit  sw_up;
        bit  fwd_flag;
        int  rate_v;
        sw_pos  = 0;
        sw_hi   = pick_reach();
        sw_lo   = -pick_reach();
        sw_step = pick_step();
        sw_up   = 1'b1;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: unclamped zero setpoints before any hit, field extremes,
        // turn capture in both directions, several slots matching at once
        push_sample(20000, 100);
        push_sample(32767, 1);
        push_sample(-32768, -1);
        push_sample(-32768, 0);
        push_sample(0, 32767);
        push_sample(0, 5);
        push_sample(0, -32768);
        push_sample(1, -3);
        push_sample(-32768, 32767);
        push_sample(32767, -32768);
        wait_drained();

        // Zero tolerance: exact target, still no match, setpoints held
        cfg_write(sps_pkg::CFG_HIT_TOLERANCE, 0);
        cfg_release();
        push_sample(0, -1);
        push_sample(0, -1);
        wait_drained();

        // Tolerance one: only an exact match counts, which checks the
        // floor rounding of a halved odd negative turn point; limits crossed
        cfg_write(sps_pkg::CFG_HIT_TOLERANCE, 1);
        cfg_write(sps_pkg::CFG_LEAD_GAIN, 63);
        cfg_write(sps_pkg::CFG_HIP_UPPER, -9000);
        cfg_write(sps_pkg::CFG_HIP_LOWER, -5000);
        cfg_write(sps_pkg::CFG_KNEE_UPPER, 32767);
        cfg_write(sps_pkg::CFG_KNEE_LOWER, -32768);
        cfg_release();
        push_sample(-301, 9);
        push_sample(-151, 9);
        push_sample(-151, 9);
        wait_drained();

        // New limits must not touch the latched pair until the next match;
        // unmapped indexes are dropped
        cfg_write(sps_pkg::CFG_HIT_TOLERANCE, 4095);
        cfg_write(sps_pkg::CFG_LEAD_GAIN, 0);
        cfg_write(sps_pkg::CFG_HIP_UPPER, 32767);
        cfg_write(sps_pkg::CFG_HIP_LOWER, -32768);
        cfg_write(sps_pkg::CFG_KNEE_UPPER, 0);
        cfg_write(sps_pkg::CFG_KNEE_LOWER, 0);
        cfg_write(CFG_SPARE_LO, 16'h0001);
        cfg_write(CFG_SPARE_HI, 16'hFFFF);
        cfg_release();
        push_sample(32767, 9);
        push_sample(100, 9);
        push_sample(100, -1);
        wait_drained();

        // Random part: swinging motion with random content, plus noise and glitches
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            if (ph < 2) begin
                tx_idle_pct = 23;
                rx_idle_pct = 54;
            end else if (ph < 5) begin
                tx_idle_pct = 54;
                rx_idle_pct = 23;
            end else begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            random_config();
            for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
                if ($urandom_range(99) < 15) begin
                    push_sample(int'($urandom_range(0, 65535)), int'($urandom_range(0, 65535)));
                end else begin
                    if (sw_up) begin
                        sw_pos = sw_pos + sw_step;
                        if (sw_pos >= sw_hi) begin
                            sw_pos  = sw_hi;
                            sw_up   = 1'b0;
                            sw_step = pick_step();
                            sw_lo   = -pick_reach();
                        end
                    end else begin
                        sw_pos = sw_pos - sw_step;
                        if (sw_pos <= sw_lo) begin
                            sw_pos  = sw_lo;
                            sw_up   = 1'b1;
                            sw_step = pick_step();
                            sw_hi   = pick_reach();
                        end
                    end
                    // occasional rate glitch against the motion
                    fwd_flag = ($urandom_range(99) < 5) ? !sw_up : sw_up;
                    if (fwd_flag) begin
                        rate_v = int'($urandom_range(1, 32767));
                    end else if ($urandom_range(9) == 0) begin
                        rate_v = 0;
                    end else begin
                        rate_v = -int'($urandom_range(1, 32768));
                    end
                    push_sample(sw_pos, rate_v);
                end
            end
            wait_drained();
        end

        $display("%0d results checked, %0d of them phase matches", results_seen, hits_seen);
        $display("%0d register writes over %0d settings, %0d mismatches",
                 cfg_writes, RANDOM_PHASES + 4, mismatches);
        if (mismatches == 0 && pending_setpoints.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

[swing_phase_setpoint_sequencer.f]
+incdir+rtl/core
rtl/core/sps_pkg.sv
rtl/core/sps_phase_match.sv
rtl/core/swing_phase_setpoint_sequencer.sv
test/testbench.sv
